/* hw/rtl/mac_learning_forward_table_unit_assert.svh */
// assertion macros shared by the learning table rtl
`ifndef MAC_LEARNING_FORWARD_TABLE_UNIT_ASSERT_SVH
`define MAC_LEARNING_FORWARD_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define MLFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mlft assertion failed");

// next-cycle implication, off while reset is asserted
`define MLFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mlft assertion failed");

`endif

/* hw/rtl/mlft_pkg.sv */
`default_nettype none
package mlft_pkg;

	localparam int DEPTH  = 256;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SW_W   = 16;
	localparam int PORT_W = 16;
	localparam int MAC_W  = 48;

	// one table slot as stored in the ram
	typedef struct packed {
		logic [SW_W-1:0]   sw;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// key of the transaction under work
	typedef struct packed {
		logic [SW_W-1:0]   sw;
		logic [MAC_W-1:0]  src;
		logic [MAC_W-1:0]  dst;
		logic [PORT_W-1:0] port;
	} key_t;

	// status from the sequencer
	typedef struct packed {
		logic              busy;
		logic              done;
		logic              forward;
		logic [PORT_W-1:0] port;
		logic              dropped;
	} res_t;

endpackage
`default_nettype wire

/* hw/rtl/mlft_ram.sv */
`default_nettype none
module mlft_ram #(
	parameter int Depth = 256,
	parameter int Width = 80
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/mlft_ctrl.sv */
`default_nettype none
`include "mac_learning_forward_table_unit_assert.svh"
module mlft_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire mlft_pkg::key_t key,
	output mlft_pkg::res_t     res
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t                              state_q;
	logic [mlft_pkg::ADDR_W-1:0]         addr_q;
	logic [mlft_pkg::CNT_W-1:0]          fill_q;
	logic                                rd_pend_s1;
	logic                                src_hit_q;
	logic                                dst_hit_q;
	logic [mlft_pkg::PORT_W-1:0]         dst_port_q;

	logic                                mem_re;
	logic                                mem_we;
	mlft_pkg::entry_t                    rd_entry;
	mlft_pkg::entry_t                    wr_entry;
	logic [mlft_pkg::ENTRY_W-1:0]        rd_raw;
	logic                                last_issue;
	logic                                full;
	logic                                learn;
	logic                                self_hit;
	logic                                sw_eq;

	assign last_issue = (mlft_pkg::CNT_W'(addr_q) == fill_q - mlft_pkg::CNT_W'(1));
	assign full       = (fill_q == mlft_pkg::CNT_W'(mlft_pkg::DEPTH));
	assign learn      = !src_hit_q && !full;
	assign self_hit   = learn && (key.src == key.dst);
	assign mem_re     = (state_q == ST_SCAN);
	assign mem_we     = (state_q == ST_COMMIT) && learn;

	assign wr_entry.sw   = key.sw;
	assign wr_entry.mac  = key.src;
	assign wr_entry.port = key.port;
	assign rd_entry      = mlft_pkg::entry_t'(rd_raw);
	assign sw_eq         = (rd_entry.sw == key.sw);

	mlft_ram #(
		.Depth (mlft_pkg::DEPTH),
		.Width (mlft_pkg::ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (fill_q[mlft_pkg::ADDR_W-1:0]),
		.wdata (wr_entry),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (rd_raw)
	);

	// sequencer: scan the filled slots, then learn and report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			addr_q     <= '0;
			fill_q     <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= mem_re;
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (go) begin
						state_q <= (fill_q == '0) ? ST_COMMIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + mlft_pkg::ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (learn) begin
						fill_q <= fill_q + mlft_pkg::CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// match tracking, lowest destination slot wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
		end else if (go && state_q == ST_IDLE) begin
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
		end else if (rd_pend_s1) begin
			if (sw_eq && rd_entry.mac == key.src) begin
				src_hit_q <= 1'b1;
			end
			if (sw_eq && rd_entry.mac == key.dst && !dst_hit_q) begin
				dst_hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1 && sw_eq && rd_entry.mac == key.dst && !dst_hit_q) begin
			dst_port_q <= rd_entry.port;
		end
	end

	always_comb begin
		res.busy    = (state_q != ST_IDLE);
		res.done    = (state_q == ST_COMMIT);
		res.forward = dst_hit_q || self_hit;
		res.dropped = !src_hit_q && full;
		if (dst_hit_q) begin
			res.port = dst_port_q;
		end else if (self_hit) begin
			res.port = key.port;
		end else begin
			res.port = '0;
		end
	end

	`MLFT_ASSERT_IMP(a_write_has_room, clk, arst_n, mem_we, !full)
	`MLFT_ASSERT_NEXT(a_commit_to_idle, clk, arst_n, state_q == ST_COMMIT, state_q == ST_IDLE)
	`MLFT_ASSERT_IMP(a_drain_has_data, clk, arst_n, state_q == ST_DRAIN, rd_pend_s1)
	`MLFT_ASSERT_IMP(a_scan_in_fill, clk, arst_n, state_q == ST_SCAN, mlft_pkg::CNT_W'(addr_q) < fill_q)

endmodule
`default_nettype wire

/* hw/rtl/mac_learning_forward_table_unit.sv */
// layer-2 learning table keyed by (switch id, mac)
// command channel: a transaction is taken at a rising edge with start high and busy low;
//   the packet-in fields are captured at that edge and need not be held afterwards
// result channel: done is high for exactly one cycle with the decision; the receiver
//   cannot stall, so the result must be taken in that cycle
// per transaction the table ram is scanned once over the n filled slots, comparing the
//   source and destination keys together on every read; the source is then learned into
//   the next free slot unless known or the table is full (learn_dropped)
// timing: after acceptance the sequencer steps through scan, drain and commit (straight to
//   commit on an empty table), and done follows commit via the result register; busy
//   drops in the done cycle, so a new start is taken then; the scan uses the single ram read port
// reset: the fill count clears, so every slot reads as free; no clearing pass is needed
//   as slots fill in order and only slots below the fill count are ever read
`default_nettype none
`include "mac_learning_forward_table_unit_assert.svh"
module mac_learning_forward_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] switch_id,
	input  wire logic [15:0] ingress_port,
	input  wire logic [47:0] source_mac,
	input  wire logic [47:0] dest_mac,
	input  wire logic [15:0] ether_type,
	input  wire logic [31:0] buffer_ref,
	output logic             done,
	output logic             forward,
	output logic [15:0]      out_port,
	output logic [15:0]      reply_switch,
	output logic [31:0]      reply_buffer,
	output logic [15:0]      match_in_port,
	output logic [47:0]      match_source,
	output logic [47:0]      match_dest,
	output logic [15:0]      match_type,
	output logic             learn_dropped
);

	logic                   accept;
	mlft_pkg::key_t         key_q;
	logic [15:0]            etype_q;
	logic [31:0]            buf_q;
	mlft_pkg::res_t         res;
	logic                   done_q;
	logic                   forward_q;
	logic [15:0]            out_port_q;
	logic                   dropped_q;

	assign busy   = res.busy;
	assign accept = start && !busy;

	// request capture; these stay put until the next accepted transaction,
	// which can land no earlier than the edge closing the done cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.sw   <= switch_id;
			key_q.src  <= source_mac;
			key_q.dst  <= dest_mac;
			key_q.port <= ingress_port;
			etype_q    <= ether_type;
			buf_q      <= buffer_ref;
		end
	end

	mlft_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.key    (key_q),
		.res    (res)
	);

	// result register, loaded in the commit cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.done;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			forward_q  <= res.forward;
			out_port_q <= res.port;
			dropped_q  <= res.dropped;
		end
	end

	assign done          = done_q;
	assign forward       = forward_q;
	assign out_port      = out_port_q;
	assign learn_dropped = dropped_q;

	// echoes come straight from the captured request
	assign reply_switch  = key_q.sw;
	assign reply_buffer  = buf_q;
	assign match_in_port = key_q.port;
	assign match_source  = key_q.src;
	assign match_dest    = key_q.dst;
	assign match_type    = etype_q;

	`MLFT_ASSERT_IMP(a_done_not_busy, clk, arst_n, done_q, !busy)
	`MLFT_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, accept, busy)
	`MLFT_ASSERT_IMP(a_flood_port_zero, clk, arst_n, done_q && !forward_q, out_port_q == '0)

endmodule
`default_nettype wire
